@@ hdl/ubxf_pkg.sv @@
package ubxf_pkg;

	localparam logic [7:0] SYNC1      = 8'hB5;
	localparam logic [7:0] SYNC2      = 8'h62;
	localparam logic [7:0] CLASS_NAV  = 8'h01;
	localparam logic [7:0] ID_PVT     = 8'h07;
	localparam logic [7:0] ID_GEOFENCE = 8'h39;
	localparam logic [7:0] PVT_LEN    = 8'd92;
	localparam logic [7:0] GEO_BASE_LEN = 8'd8;

	localparam logic RK_PAYLOAD = 1'b0;
	localparam logic RK_STATUS  = 1'b1;

	localparam logic MK_PVT      = 1'b0;
	localparam logic MK_GEOFENCE = 1'b1;

	typedef struct packed {
		logic       last;
		logic       checksum_ok;
		logic [6:0] byte_index;
		logic [7:0] payload_byte;
		logic       msg_kind;
		logic       result_kind;
	} result_t;

endpackage

@@ hdl/ubxf_parser.sv @@
module ubxf_parser
	import ubxf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_wdata,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_SYNC2 = 4'd1,
		PH_CLASS = 4'd2,
		PH_ID    = 4'd3,
		PH_LENLO = 4'd4,
		PH_LENHI = 4'd5,
		PH_DATA  = 4'd6,
		PH_CKA   = 4'd7,
		PH_CKB   = 4'd8
	} phase_t;

	phase_t     phase_q, phase_d;
	logic       kind_q, kind_d;
	logic [7:0] len_lo_q, len_lo_d;
	logic [6:0] plen_q, plen_d;
	logic [6:0] count_q, count_d;
	logic [7:0] sum_a_q, sum_a_d;
	logic [7:0] sum_b_q, sum_b_d;
	logic [7:0] ck_a_q, ck_a_d;
	logic [2:0] fence_q;

	logic [7:0] add_a;
	logic [7:0] add_b;
	logic [7:0] want_len;

	// running fletcher sums, class byte restarts them
	always_comb begin
		if (phase_q == PH_CLASS) begin
			add_a = rx_byte;
			add_b = rx_byte;
		end else begin
			add_a = sum_a_q + rx_byte;
			add_b = sum_b_q + add_a;
		end
	end

	assign want_len = kind_q ? (GEO_BASE_LEN + {4'd0, fence_q, 1'b0}) : PVT_LEN;

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		len_lo_d  = len_lo_q;
		plen_d    = plen_q;
		count_d   = count_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		ck_a_d    = ck_a_q;
		res_valid = 1'b0;
		res       = '0;
		res.msg_kind = kind_q;
		unique case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == SYNC2)
					phase_d = PH_CLASS;
				else if (rx_byte != SYNC1)
					phase_d = PH_HUNT;
			end
			PH_CLASS: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				phase_d = (rx_byte == CLASS_NAV) ? PH_ID : PH_HUNT;
			end
			PH_ID: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (rx_byte == ID_PVT) begin
					kind_d  = MK_PVT;
					phase_d = PH_LENLO;
				end else if (rx_byte == ID_GEOFENCE) begin
					kind_d  = MK_GEOFENCE;
					phase_d = PH_LENLO;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LENLO: begin
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				len_lo_d = rx_byte;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (rx_byte == 8'd0 && len_lo_q == want_len) begin
					plen_d  = want_len[6:0];
					count_d = '0;
					phase_d = PH_DATA;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				sum_a_d   = add_a;
				sum_b_d   = add_b;
				res_valid = 1'b1;
				res.result_kind  = RK_PAYLOAD;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
				count_d = count_q + 7'd1;
				if (count_d == plen_q)
					phase_d = PH_CKA;
			end
			PH_CKA: begin
				ck_a_d  = rx_byte;
				phase_d = PH_CKB;
			end
			PH_CKB: begin
				res_valid = 1'b1;
				res.result_kind = RK_STATUS;
				res.checksum_ok = (ck_a_q == sum_a_q) && (rx_byte == sum_b_q);
				res.last        = 1'b1;
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == SYNC1) ? PH_SYNC2 : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			kind_q   <= 1'b0;
			len_lo_q <= '0;
			plen_q   <= '0;
			count_q  <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			ck_a_q   <= '0;
			fence_q  <= '0;
		end else begin
			if (cfg_wen)
				fence_q <= cfg_wdata;
			if (step) begin
				phase_q  <= phase_d;
				kind_q   <= kind_d;
				len_lo_q <= len_lo_d;
				plen_q   <= plen_d;
				count_q  <= count_d;
				sum_a_q  <= sum_a_d;
				sum_b_q  <= sum_b_d;
				ck_a_q   <= ck_a_d;
			end
		end
	end

endmodule

@@ hdl/ubxf_out_fifo.sv @@
module ubxf_out_fifo
	import ubxf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    full,
	output logic    rd_valid,
	input  logic    rd_ready,
	output result_t rd_data
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, wr_en} - {1'b0, do_rd};
		end
	end

endmodule

@@ hdl/ubx_frame_receiver_filter_core.sv @@
// path: an accepted byte is held in the input register, then any result it gives is written into
// the two-entry output queue, whose head is offered as the output transfer
// throughput: one byte per cycle when not stalled, set by the single-pass parser and the queue
// input stalls only while the output queue is full and a byte waits in the input register
// reset: asynchronous, active low; parser returns to hunting, sums and fence count clear,
// output queue empties
module ubx_frame_receiver_filter_core
	import ubxf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,     // fence_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // payload_byte, byte_index, checksum_ok
	output logic [1:0]  m_axis_tuser,  // result_kind, msg_kind
	output logic        m_axis_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fifo_full;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign advance       = valid_s1 && !fifo_full;
	assign s_axis_tready = !valid_s1 || !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			byte_s1 <= s_axis_tdata;
	end

	ubxf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ubxf_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (advance && res_valid),
		.wr_data  (res),
		.full     (fifo_full),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (out_res)
	);

	assign m_axis_tdata = {out_res.checksum_ok, out_res.byte_index, out_res.payload_byte};
	assign m_axis_tuser = {out_res.msg_kind, out_res.result_kind};
	assign m_axis_tlast = out_res.last;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input register empty but not ready");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_full |-> !advance)
		else $error("parser stepped while output queue full");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
		else $error("tlast disagrees with result kind");

	a_payload_no_ck: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> !m_axis_tdata[15])
		else $error("checksum flag set on payload transfer");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_full && !m_axis_tready) |=> fifo_full)
		else $error("output queue lost an entry while stalled");

endmodule
